>>> rtl/rbrr_pkg.sv
// Shared types and constants for the ring buffer rate resampler.
// Used by rbrr_shaper, rbrr_ring and ring_buffer_rate_resampler; no dependencies.
package rbrr_pkg;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned VALUE_W     = 13;
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned TABLE_DEPTH = 4096;
    localparam int unsigned TABLE_AW    = 12;

    localparam logic [VALUE_W-1:0]  MIDSCALE        = 13'd2048;
    localparam logic [SAMPLE_W-1:0] DAC_MAX         = 12'd4095;
    localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RESET = 12'd64;

    typedef enum logic
    {
        KIND_AUDIO = 1'b0,
        KIND_TABLE = 1'b1
    } kind_t;

    // Request from the pipeline into the ring memory for one audio word.
    typedef struct packed
    {
        logic               en;
        logic [VALUE_W-1:0] wdata;
    } ring_req_t;

endpackage

>>> rtl/rbrr_shaper.sv
// Shaping table memory with a registered read, followed by the
// dead-zone snap to midscale. Depends on rbrr_pkg.
module rbrr_shaper
(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [rbrr_pkg::TABLE_AW-1:0]       wr_addr,
    input  logic [rbrr_pkg::VALUE_W-1:0]        wr_data,
    input  logic                                rd_en,
    input  logic [rbrr_pkg::TABLE_AW-1:0]       rd_addr,
    input  logic [rbrr_pkg::SAMPLE_W-1:0]       dead_zone,
    output logic [rbrr_pkg::VALUE_W-1:0]        shaped
);

    logic [rbrr_pkg::VALUE_W-1:0] table_mem [rbrr_pkg::TABLE_DEPTH];
    logic [rbrr_pkg::VALUE_W-1:0] q_reg;
    logic [rbrr_pkg::VALUE_W-1:0] dev;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        if (q_reg >= rbrr_pkg::MIDSCALE)
        begin
            dev = q_reg - rbrr_pkg::MIDSCALE;
        end
        else
        begin
            dev = rbrr_pkg::MIDSCALE - q_reg;
        end
        if (dev < {1'b0, dead_zone})
        begin
            shaped = rbrr_pkg::MIDSCALE;
        end
        else
        begin
            shaped = q_reg;
        end
    end

endmodule

>>> rtl/rbrr_ring.sv
// Ring store memory with write pointer, fill tracking and same-slot forwarding.
// Depends on rbrr_pkg.
module rbrr_ring #(
    parameter int unsigned RING_DEPTH = 4096
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rbrr_pkg::ring_req_t                req,
    input  logic [$clog2(RING_DEPTH)-1:0]      slot,
    output logic [rbrr_pkg::VALUE_W-1:0]       rd_value
);

    localparam int unsigned RING_AW = $clog2(RING_DEPTH);
    localparam logic [RING_AW-1:0] LAST_SLOT = RING_AW'(RING_DEPTH - 1);

    logic [rbrr_pkg::VALUE_W-1:0] ring_mem [RING_DEPTH];
    logic [rbrr_pkg::VALUE_W-1:0] q_reg;
    logic [rbrr_pkg::VALUE_W-1:0] fwd_val_reg;
    logic                         fwd_reg;
    logic                         known_reg;
    logic [RING_AW-1:0]           wp_reg;
    logic [RING_AW-1:0]           wp_next;
    logic                         wrapped_reg;

    assign wp_next = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            ring_mem[wp_reg] <= req.wdata;
            q_reg            <= ring_mem[slot];
            // The slot written in this step reads back the new value.
            fwd_reg          <= (slot == wp_reg);
            fwd_val_reg      <= req.wdata;
            // Slots are filled in order, so anything at or below the pointer,
            // or anything once the ring has wrapped, has been written.
            known_reg        <= wrapped_reg || (slot <= wp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (req.en)
        begin
            wp_reg <= wp_next;
            if (wp_reg == LAST_SLOT)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rd_value = fwd_val_reg;
        end
        else if (known_reg)
        begin
            rd_value = q_reg;
        end
        else
        begin
            rd_value = '0;
        end
    end

endmodule

>>> rtl/ring_buffer_rate_resampler.sv
// Ring buffer rate resampler: shaping table, dead zone, ring store, phase read.
// Each audio word passes the table read, ring read and output registers; one word per
// cycle unless out_stall holds the pipeline. The rate is set by the single shared
// pipeline enable over both memories' read ports. Table-write words give no result.
// Reset clears the pipeline, pointers and phase and sets dead_zone to 64; the ring
// reads as zero until written (fill tracking, no clearing pass). The table is undefined.
module ring_buffer_rate_resampler #(
    parameter int unsigned RING_DEPTH = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rbrr_pkg::SAMPLE_W-1:0]       cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [rbrr_pkg::SAMPLE_W-1:0]       sample,
    input  logic [rbrr_pkg::PHASE_W-1:0]        speed,
    input  logic [rbrr_pkg::TABLE_AW-1:0]       table_index,
    input  logic [rbrr_pkg::VALUE_W-1:0]        table_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rbrr_pkg::SAMPLE_W-1:0]       dac_value
);

    localparam int unsigned RING_AW = $clog2(RING_DEPTH);

    logic                              adv;
    logic                              accept;
    logic                              audio_acc;
    logic                              table_wr;
    logic [rbrr_pkg::SAMPLE_W-1:0]     dead_zone_reg;
    logic [rbrr_pkg::PHASE_W-1:0]      phase_reg;
    logic [rbrr_pkg::PHASE_W-1:0]      phase_next;
    logic [rbrr_pkg::PHASE_W-1:0]      s1_phase_reg;
    logic                              s1_valid_reg;
    logic                              s2_valid_reg;
    logic                              out_valid_reg;
    logic [rbrr_pkg::SAMPLE_W-1:0]     dac_value_reg;
    logic [rbrr_pkg::SAMPLE_W-1:0]     dac_value_next;
    logic [rbrr_pkg::VALUE_W-1:0]      shaped;
    logic [rbrr_pkg::VALUE_W-1:0]      ring_value;
    rbrr_pkg::ring_req_t               ring_req;

    // The whole pipeline moves together whenever the output register can take a word.
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign audio_acc = accept && (rbrr_pkg::kind_t'(kind) == rbrr_pkg::KIND_AUDIO);
    assign table_wr  = accept && (rbrr_pkg::kind_t'(kind) == rbrr_pkg::KIND_TABLE);
    assign phase_next = phase_reg + speed;

    assign ring_req.en    = adv && s1_valid_reg;
    assign ring_req.wdata = shaped;

    assign dac_value_next = (ring_value > {1'b0, rbrr_pkg::DAC_MAX}) ?
                            rbrr_pkg::DAC_MAX : ring_value[rbrr_pkg::SAMPLE_W-1:0];

    assign out_valid = out_valid_reg;
    assign dac_value = dac_value_reg;

    rbrr_shaper u_shaper
    (
        .clk       (clk),
        .wr_en     (table_wr),
        .wr_addr   (table_index),
        .wr_data   (table_value),
        .rd_en     (audio_acc),
        .rd_addr   (sample),
        .dead_zone (dead_zone_reg),
        .shaped    (shaped)
    );

    rbrr_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ring_req),
        .slot     (s1_phase_reg[rbrr_pkg::PHASE_W-1 -: RING_AW]),
        .rd_value (ring_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= rbrr_pkg::DEAD_ZONE_RESET;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dead_zone_reg <= cfg_wr_data;
            end
            if (audio_acc)
            begin
                phase_reg <= phase_next;
            end
            if (adv)
            begin
                s1_valid_reg  <= audio_acc;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (audio_acc)
        begin
            s1_phase_reg <= phase_next;
        end
        if (adv && s2_valid_reg)
        begin
            dac_value_reg <= dac_value_next;
        end
    end

endmodule

>>> verif/ring_buffer_rate_resampler_tb.sv
// Self-checking testbench for ring_buffer_rate_resampler: a directed table of words, then
// random phases at several dead-zone settings, checked against a predictor held in the bench.
// Depends on rbrr_pkg and the block's RTL only.
module ring_buffer_rate_resampler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned        RING_AW      = 12;
    localparam int unsigned        RING_SLOTS   = 1 << RING_AW;
    localparam int unsigned        IDLE_LIMIT   = 2000;
    localparam int unsigned        DRAIN_CYCLES = 8;
    localparam int unsigned        HOLD_CYCLES  = 80;
    localparam int unsigned        PHASE_WORDS  = 115;
    localparam int unsigned        NUM_PHASES   = 6;
    localparam logic [rbrr_pkg::PHASE_W-1:0] UNITY_SPEED = 32'h0010_0000;

    typedef struct packed
    {
        rbrr_pkg::kind_t                kind;
        logic [rbrr_pkg::SAMPLE_W-1:0]  sample;
        logic [rbrr_pkg::PHASE_W-1:0]   speed;
        logic [rbrr_pkg::TABLE_AW-1:0]  table_index;
        logic [rbrr_pkg::VALUE_W-1:0]   table_value;
    } in_word_t;

    typedef struct packed
    {
        in_word_t                       word;
        logic                           known;
        logic [rbrr_pkg::SAMPLE_W-1:0]  dac;
    } directed_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [rbrr_pkg::SAMPLE_W-1:0]  cfg_wr_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           kind;
    logic [rbrr_pkg::SAMPLE_W-1:0]  sample;
    logic [rbrr_pkg::PHASE_W-1:0]   speed;
    logic [rbrr_pkg::TABLE_AW-1:0]  table_index;
    logic [rbrr_pkg::VALUE_W-1:0]   table_value;
    logic                           out_valid;
    logic                           out_stall;
    logic [rbrr_pkg::SAMPLE_W-1:0]  dac_value;

    // Predictor state: a copy of everything the block keeps.
    logic [rbrr_pkg::VALUE_W-1:0]   shape_tbl [rbrr_pkg::TABLE_DEPTH];
    bit                             tbl_loaded [rbrr_pkg::TABLE_DEPTH];
    logic [rbrr_pkg::TABLE_AW-1:0]  loaded_list [$];
    logic [rbrr_pkg::VALUE_W-1:0]   ring_mem [RING_SLOTS];
    logic [RING_AW-1:0]             wr_ptr;
    logic [rbrr_pkg::PHASE_W-1:0]   rd_phase;
    logic [rbrr_pkg::SAMPLE_W-1:0]  dead_zone;

    logic [rbrr_pkg::SAMPLE_W-1:0]  dac_expect_q [$];
    int unsigned                    fail_cnt;
    bit                             gaps_on;
    int unsigned                    hold_asked;

    // Table loads first, then audio words; for all but the last two the result can be
    // read straight off the table: the read slot follows the write pointer at unity speed.
    directed_row_t directed_rows [19] = '{
        '{'{rbrr_pkg::KIND_TABLE, 12'hFFF, 32'hFFFF_FFFF, 12'd0,    13'd0},    1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'h000, 32'h0000_0000, 12'd4095, 13'd4095}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'hFFF, 32'hFFFF_FFFF, 12'd2048, 13'd2048}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'h000, 32'h0000_0000, 12'd1,    13'd8191}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'hFFF, 32'hFFFF_FFFF, 12'd2,    13'd4096}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'h000, 32'h0000_0000, 12'd3,    13'd2111}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'hFFF, 32'hFFFF_FFFF, 12'd4,    13'd2112}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'h000, 32'h0000_0000, 12'd5,    13'd1985}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_TABLE, 12'hFFF, 32'hFFFF_FFFF, 12'd6,    13'd1984}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd0,    32'h0000_0000, 12'hFFF, 13'h1FFF}, 1'b1, 12'd0},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd4095, 32'h0010_0000, 12'h000, 13'h0000}, 1'b1, 12'd4095},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd1,    32'h0010_0000, 12'hFFF, 13'h1FFF}, 1'b1, 12'd4095},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd2,    32'h0010_0000, 12'h000, 13'h0000}, 1'b1, 12'd4095},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd3,    32'h0010_0000, 12'hFFF, 13'h1FFF}, 1'b1, 12'd2048},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd4,    32'h0010_0000, 12'h000, 13'h0000}, 1'b1, 12'd2112},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd5,    32'h0010_0000, 12'hFFF, 13'h1FFF}, 1'b1, 12'd2048},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd6,    32'h0010_0000, 12'h000, 13'h0000}, 1'b1, 12'd1984},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd2048, 32'hFFFF_FFFF, 12'hFFF, 13'h1FFF}, 1'b0, 12'd0},
        '{'{rbrr_pkg::KIND_AUDIO, 12'd4095, 32'h8000_0000, 12'h000, 13'h0000}, 1'b0, 12'd0}
    };

    ring_buffer_rate_resampler #(
        .RING_DEPTH (RING_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .sample      (sample),
        .speed       (speed),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dac_value   (dac_value)
    );

    always #5ns clk = ~clk;

    function automatic void reset_model();
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            ring_mem[i] = '0;
        end
        for (int i = 0; i < rbrr_pkg::TABLE_DEPTH; i++)
        begin
            shape_tbl[i]  = '0;
            tbl_loaded[i] = 1'b0;
        end
        loaded_list.delete();
        wr_ptr    = '0;
        rd_phase  = '0;
        dead_zone = rbrr_pkg::DEAD_ZONE_RESET;
    endfunction

    // Returns 1 with the DAC value when the word is audio; table words only load the table.
    function automatic bit predict_resample(input in_word_t w,
                                            output logic [rbrr_pkg::SAMPLE_W-1:0] dac);
        logic [rbrr_pkg::VALUE_W-1:0] shaped;
        logic [rbrr_pkg::VALUE_W-1:0] dev;
        logic [rbrr_pkg::VALUE_W-1:0] rd;
        dac = '0;
        if (w.kind == rbrr_pkg::KIND_TABLE)
        begin
            shape_tbl[w.table_index] = w.table_value;
            if (!tbl_loaded[w.table_index])
            begin
                tbl_loaded[w.table_index] = 1'b1;
                loaded_list.push_back(w.table_index);
            end
            return 1'b0;
        end
        shaped = shape_tbl[w.sample];
        dev    = (shaped >= rbrr_pkg::MIDSCALE) ? shaped - rbrr_pkg::MIDSCALE
                                                : rbrr_pkg::MIDSCALE - shaped;
        if (dev < {1'b0, dead_zone})
        begin
            shaped = rbrr_pkg::MIDSCALE;
        end
        // The write lands before the read, so a read of the same slot sees the new value.
        ring_mem[wr_ptr] = shaped;
        wr_ptr           = wr_ptr + 1'b1;
        rd_phase         = rd_phase + w.speed;
        rd               = ring_mem[rd_phase[rbrr_pkg::PHASE_W-1 -: RING_AW]];
        dac              = (rd > {1'b0, rbrr_pkg::DAC_MAX}) ? rbrr_pkg::DAC_MAX
                                                            : rd[rbrr_pkg::SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       val;
        w.sample      = rbrr_pkg::SAMPLE_W'($urandom_range(0, 4095));
        w.speed       = $urandom;
        w.table_index = rbrr_pkg::TABLE_AW'($urandom_range(0, 4095));
        w.table_value = rbrr_pkg::VALUE_W'($urandom_range(0, 8191));
        if (loaded_list.size() == 0 || $urandom_range(0, 9) < 2)
        begin
            w.kind = rbrr_pkg::KIND_TABLE;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    val = $urandom_range(0, 4096);
                end
                2:
                begin
                    val = $urandom_range(4097, 8191);
                end
                default:
                begin
                    // Cluster around the dead-zone edges, where snapping flips.
                    val = int'(rbrr_pkg::MIDSCALE) - int'(dead_zone) - 2
                        + int'($urandom_range(0, 2 * dead_zone + 4));
                    if (val < 0)
                    begin
                        val = 0;
                    end
                    if (val > 4096)
                    begin
                        val = 4096;
                    end
                end
            endcase
            w.table_value = val[rbrr_pkg::VALUE_W-1:0];
        end
        else
        begin
            w.kind   = rbrr_pkg::KIND_AUDIO;
            w.sample = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            case ($urandom_range(0, 7))
                0, 1:    w.speed = UNITY_SPEED;
                2:       w.speed = UNITY_SPEED + $urandom_range(0, 4096) - 2048;
                3:       w.speed = $urandom_range(1, 32'h0040_0000);
                4:       w.speed = 32'hFFFF_FFFF - $urandom_range(0, 32'h0020_0000);
                5:       w.speed = UNITY_SPEED << $urandom_range(0, 11);
                default: w.speed = $urandom;
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input logic known,
                             input logic [rbrr_pkg::SAMPLE_W-1:0] known_dac);
        int unsigned                    gap;
        logic [rbrr_pkg::SAMPLE_W-1:0]  dac;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= w.kind;
        sample      <= w.sample;
        speed       <= w.speed;
        table_index <= w.table_index;
        table_value <= w.table_value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (predict_resample(w, dac))
        begin
            dac_expect_q.push_back(known ? known_dac : dac);
        end
    endtask

    // Table words give no result, so wait out the pipeline after the last one has come.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (dac_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_dead_zone(input logic [rbrr_pkg::SAMPLE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        dead_zone    = value;
    endtask

    task automatic check_dac(input logic [rbrr_pkg::SAMPLE_W-1:0] got);
        logic [rbrr_pkg::SAMPLE_W-1:0] want;
        if (dac_expect_q.size() == 0)
        begin
            $error("dac_value: expected none, actual %0d", got);
            fail_cnt++;
        end
        else
        begin
            want = dac_expect_q.pop_front();
            if (got !== want)
            begin
                $error("dac_value: expected %0d, actual %0d", want, got);
                fail_cnt++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [rbrr_pkg::SAMPLE_W-1:0] dz_plan [NUM_PHASES];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        kind        = rbrr_pkg::KIND_AUDIO;
        sample      = '0;
        speed       = '0;
        table_index = '0;
        table_value = '0;
        fail_cnt    = 0;
        gaps_on     = 1'b1;
        hold_asked  = 0;
        reset_model();
        dz_plan[0] = 12'd0;
        dz_plan[1] = 12'd2048;
        dz_plan[2] = rbrr_pkg::SAMPLE_W'($urandom_range(2, 2046));
        dz_plan[3] = 12'd2047;
        dz_plan[4] = 12'd1;
        dz_plan[5] = rbrr_pkg::SAMPLE_W'($urandom_range(2, 2046));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].dac);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_dead_zone(dz_plan[p]);
            // Every other phase opens with the receiver held off and the sender flat out,
            // so the pipeline fills and the input side stalls.
            if (p % 2 == 1)
            begin
                gaps_on = 1'b0;
                hold_asked <= hold_asked + 1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 32 == 31)
                begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                end
                send_word(random_word(), 1'b0, '0);
            end
        end

        drain_results();
        if (fail_cnt == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin : result_sink
        int unsigned wait_left;
        int unsigned hold_left;
        int unsigned hold_done;
        out_stall = 1'b0;
        wait_left = 0;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                check_dac(dac_value);
                wait_left = gaps_on ? $urandom_range(0, 5) : 0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            if (hold_asked != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            out_stall <= (hold_left > 0) || (wait_left > 0);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
